FILE: src/itmr_pkg.sv
`default_nettype none

package itmr_pkg;

	// Bus request kinds.
	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_RD16 = 2'd1,
		REQ_RD8  = 2'd2,
		REQ_WR16 = 2'd3
	} itmr_op_t;

	// Register map; bits 11..6 of the address pick the register.
	localparam logic [11:0] SEL_MASK     = 12'hFC0;
	localparam logic [11:0] ADDR_CONTROL = 12'hF00;
	localparam logic [11:0] ADDR_PERIOD  = 12'hF80;
	localparam logic [11:0] ADDR_COUNTER = 12'hFC0;

	// Control register bit positions.
	localparam int CTL_IRQ_EN   = 0;
	localparam int CTL_COUNT_EN = 1;
	localparam int CTL_FLAG     = 2;

	// A period of zero stands for 65536.
	localparam logic [16:0] PERIOD_FULL = 17'h10000;

	typedef struct packed {
		itmr_op_t    req_type;
		logic [11:0] address;
		logic [15:0] write_data;
	} itmr_req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_line;
	} itmr_rsp_t;

endpackage

`default_nettype wire

FILE: src/interval_timer_with_irq.sv
// A result shows on rsp once its request has passed the input register
// and then the result register, which loads only while the output is free.
// One request per cycle is sustained while the output is not stalled; the
// input register and the result register each advance every such cycle.
// The critical path is the reciprocal multiply behind a counter read.
// Reset (arst_n low) clears control, period, counter and both valid flags.
`default_nettype none

module interval_timer_with_irq #(
	parameter int PRESCALE = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire itmr_pkg::itmr_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output itmr_pkg::itmr_rsp_t      rsp
);
	import itmr_pkg::*;

	// The counter must hold the longest effective period, 65536 * PRESCALE.
	localparam int CNT_W = $clog2(65536 * PRESCALE + 1);

	// Stage 1 holds the accepted request; stage 2 holds its result.
	logic      valid_s1;
	itmr_req_t req_s1;
	logic      rsp_valid_s2;
	itmr_rsp_t rsp_s2;
	itmr_rsp_t rsp_c;
	logic      adv;
	logic      exec;

	// The result register can take a new value when it is empty or being
	// drained this cycle. The request in stage 1 executes exactly then, and
	// stage 1 refills in the same cycle, so back-to-back requests flow.
	assign adv       = !rsp_valid_s2 || !rsp_stall;
	assign exec      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;

	itmr_core #(
		.PRESCALE(PRESCALE),
		.CNT_W   (CNT_W)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.exec  (exec),
		.req   (req_s1),
		.rsp   (rsp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset; their valid flags guard them.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (exec) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

FILE: src/itmr_div.sv
`default_nettype none

// Rounded-up quotient of the counter by PRESCALE through a reciprocal
// multiply that is exact over the whole counter range.
module itmr_div #(
	parameter int PRESCALE = 15,
	parameter int CNT_W    = 20
) (
	input  wire logic [CNT_W-1:0] count,
	output logic [15:0]           quot
);
	localparam int NUM_W = CNT_W + 1;
	localparam int SH    = NUM_W + $clog2(PRESCALE);
	localparam int RW    = NUM_W + 1;
	localparam int PW    = NUM_W + RW;
	localparam longint unsigned RECIP_L =
		((64'd1 << SH) + 64'(PRESCALE) - 64'd1) / 64'(PRESCALE);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

	logic [NUM_W-1:0] num;
	logic [PW-1:0]    prod;

	assign num  = {1'b0, count} + NUM_W'(PRESCALE - 1);
	assign prod = PW'(num) * PW'(RECIP);
	assign quot = prod[SH+15:SH];

endmodule

`default_nettype wire

FILE: src/itmr_core.sv
`default_nettype none

// Timer state and the combinational execution of one request, committed when exec is high.
module itmr_core #(
	parameter int PRESCALE = 15,
	parameter int CNT_W    = 20
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              exec,
	input  wire itmr_pkg::itmr_req_t req,
	output itmr_pkg::itmr_rsp_t    rsp
);
	import itmr_pkg::*;

	logic [2:0]       ctl_q, ctl_d;
	logic [15:0]      period_q, period_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [16:0]      per_ext;
	logic [CNT_W-1:0] reload_val;
	logic [15:0]      cnt_rd;
	logic [15:0]      reg16;
	logic [15:0]      rd;
	logic [11:0]      sel;

	itmr_div #(
		.PRESCALE(PRESCALE),
		.CNT_W   (CNT_W)
	) u_div (
		.count(cnt_q),
		.quot (cnt_rd)
	);

	assign per_ext    = (period_q == 16'd0) ? PERIOD_FULL : {1'b0, period_q};
	assign reload_val = CNT_W'(per_ext) * CNT_W'(PRESCALE);
	assign sel        = req.address & SEL_MASK;

	always_comb begin
		unique case (sel)
			ADDR_CONTROL: reg16 = {13'd0, ctl_q};
			ADDR_PERIOD:  reg16 = period_q;
			ADDR_COUNTER: reg16 = cnt_rd;
			default:      reg16 = 16'd0;
		endcase
	end

	always_comb begin
		ctl_d    = ctl_q;
		period_d = period_q;
		cnt_d    = cnt_q;
		rd       = 16'd0;
		unique case (req.req_type)
			REQ_TICK: begin
				if (ctl_q[CTL_COUNT_EN]) begin
					if (cnt_q <= CNT_W'(1)) begin
						// Reload; a zero count wraps to one below the reload value, period times PRESCALE.
						cnt_d = cnt_q + reload_val - CNT_W'(1);
						if (ctl_q[CTL_IRQ_EN]) begin
							ctl_d[CTL_FLAG] = 1'b1;
						end
					end else begin
						cnt_d = cnt_q - CNT_W'(1);
					end
				end
			end
			REQ_RD16: begin
				rd = reg16;
			end
			REQ_RD8: begin
				rd = {8'h00, req.address[0] ? reg16[15:8] : reg16[7:0]};
			end
			REQ_WR16: begin
				if (sel == ADDR_CONTROL) begin
					if (!ctl_q[CTL_COUNT_EN] && req.write_data[CTL_COUNT_EN]) begin
						cnt_d = reload_val;
					end
					ctl_d = req.write_data[2:0];
				end else if (sel == ADDR_PERIOD) begin
					period_d = req.write_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.read_data = rd;
	assign rsp.irq_line  = ctl_d[CTL_FLAG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= 3'd0;
			period_q <= 16'd0;
			cnt_q    <= '0;
		end else if (exec) begin
			ctl_q    <= ctl_d;
			period_q <= period_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/itmr_chk.sv
`default_nettype none

module itmr_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire itmr_pkg::itmr_rsp_t rsp
);

	// The input side only backs up when the output side does.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("request stalled while the result side is free");

	// An accepted request reaches the output through stage 1 and the result register when unblocked.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
		else $error("result missing after an accepted request");

	// A stalled result stays valid and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind interval_timer_with_irq itmr_chk u_itmr_chk (.*);

`default_nettype wire
